/* rtl/adsr_pkg.sv */
// ----------------------------------------------------------------------------
// ADSR envelope generator package
// Shared widths, codes and types for the envelope generator and its divider.
// ----------------------------------------------------------------------------
`default_nettype none

package adsr_pkg;

  localparam int MAX_STEP_DEF  = 16;
  localparam int FRAC_BITS_DEF = 32;

  localparam int LEVEL_W    = 17;
  localparam int PHASE_W    = 3;
  localparam int CMD_W      = 2;
  localparam int STEP_IN_W  = 5;
  localparam int TIME_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 17'h10000;

  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd2;

  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd3;
  localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd3;

  localparam logic [TIME_W-1:0]  RST_ATTACK  = 20'd480;
  localparam logic [TIME_W-1:0]  RST_DECAY   = 20'd9600;
  localparam logic [LEVEL_W-1:0] RST_SUSTAIN = 17'd45875;
  localparam logic [TIME_W-1:0]  RST_RELEASE = 20'd9600;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

/* rtl/adsr_intf.sv */
// ----------------------------------------------------------------------------
// ADSR envelope generator channels
// Valid/ready channels for commands, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface adsr_in_if;
  logic                             valid;
  logic                             ready;
  logic [adsr_pkg::CMD_W-1:0]       command;
  logic [adsr_pkg::STEP_IN_W-1:0]   step_count;

  modport source (output valid, output command, output step_count, input ready);
  modport sink (input valid, input command, input step_count, output ready);
endinterface

interface adsr_out_if;
  logic                           valid;
  logic                           ready;
  logic [adsr_pkg::LEVEL_W-1:0]   level;
  logic [adsr_pkg::PHASE_W-1:0]   phase_now;

  modport source (output valid, output level, output phase_now, input ready);
  modport sink (input valid, input level, input phase_now, output ready);
endinterface

interface adsr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [adsr_pkg::CFG_IDX_W-1:0]    index;
  logic [adsr_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/adsr_div.sv */
// ----------------------------------------------------------------------------
// ADSR slope divider
// Restoring divider, one quotient bit per cycle, rounding the quotient up.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 20
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [NUM_W-1:0]   num,
  input  wire logic [DEN_W-1:0]   den,
  output logic      [NUM_W-1:0]   quo,
  output adsr_pkg::div_stat_t     stat
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             run_r, run_nxt;
  logic             round_r, round_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    run_nxt   = run_r;
    round_nxt = 1'b0;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    quo_nxt   = quo_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(NUM_W);
      num_nxt = num;
      rem_nxt = '0;
      den_nxt = (den == '0) ? DEN_W'(1) : den;
    end else if (run_r) begin
      num_nxt = {num_r[NUM_W-2:0], ge};
      rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt   = 1'b0;
        round_nxt = 1'b1;
      end
    end else if (round_r) begin
      quo_nxt  = num_r + NUM_W'(rem_r != '0);
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      round_r <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      run_r   <= run_nxt;
      round_r <= round_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign quo       = quo_r;
  assign stat.busy = run_r | round_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

/* rtl/adsr_envelope_generator_core.sv */
// ----------------------------------------------------------------------------
// Linear ADSR envelope generator
// Attack, decay, sustain and release of one envelope level in fixed point.
// ----------------------------------------------------------------------------
// Commands arrive on in_chan (tick, note on, note off) and each one yields
// exactly one word on out_chan with the level after the command (65536 is
// full scale) and the current phase. Register writes on cfg_chan are always
// taken and should only be made while the block is idle.
// For a tick, the slope times step product is registered at acceptance,
// then the S_TICK state does the clamp and stage update and S_DONE loads
// the output register. A note off while idle and an unused command code go
// straight to S_DONE.
// A note on and a note off outside the idle phase recompute the slope on
// the serial divider, one quotient bit per cycle, and S_DONE follows once
// the divider is done. A tick that ends the attack also waits for the
// divider, which then computes the decay slope.
// The block takes one command at a time; in_chan is ready again once the
// result word is in the output register, even while out_chan is stalled.
// A stalled out_chan holds the finished word and the next result waits.
// After reset the level is zero, the phase is idle and the registers hold
// their default times and sustain level.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_envelope_generator_core #(
  parameter int MAX_STEP  = adsr_pkg::MAX_STEP_DEF,
  parameter int FRAC_BITS = adsr_pkg::FRAC_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  adsr_in_if.sink   in_chan,
  adsr_out_if.source out_chan,
  adsr_cfg_if.sink  cfg_chan
);

  localparam int ACC_W   = adsr_pkg::LEVEL_W + FRAC_BITS;
  localparam int STEP_W  = $clog2(MAX_STEP + 1);
  localparam int CMP_W   = (STEP_W > adsr_pkg::STEP_IN_W) ? STEP_W : adsr_pkg::STEP_IN_W;
  localparam int DELTA_W = ACC_W + STEP_W;
  localparam logic [ACC_W-1:0] FULL_ACC = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TICK = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                       state_r, state_nxt;
  logic [adsr_pkg::PHASE_W-1:0]     stage_r, stage_nxt;
  logic [ACC_W-1:0]                 level_r, level_nxt;
  logic [ACC_W-1:0]                 slope_r, slope_nxt;
  logic [DELTA_W-1:0]               delta_r, delta_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [adsr_pkg::LEVEL_W-1:0]     out_level_r, out_level_nxt;
  logic [adsr_pkg::PHASE_W-1:0]     out_phase_r, out_phase_nxt;
  logic [adsr_pkg::TIME_W-1:0]      attack_r, decay_r, release_r;
  logic [adsr_pkg::LEVEL_W-1:0]     sustain_r;

  logic                             accept;
  logic [CMP_W-1:0]                 n_wide;
  logic [STEP_W-1:0]                n_sat;
  logic [adsr_pkg::LEVEL_W-1:0]     sus_clamp;
  logic [ACC_W-1:0]                 sus_acc;
  logic [ACC_W-1:0]                 head_room;
  logic [ACC_W-1:0]                 above_sus;
  logic                             div_start;
  logic [ACC_W-1:0]                 div_num;
  logic [adsr_pkg::TIME_W-1:0]      div_den;
  logic [ACC_W-1:0]                 div_quo;
  adsr_pkg::div_stat_t              div_stat;

  assign accept        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;

  assign n_wide    = CMP_W'(in_chan.step_count);
  assign n_sat     = (n_wide > CMP_W'(MAX_STEP)) ? STEP_W'(MAX_STEP) : STEP_W'(n_wide);
  assign sus_clamp = (sustain_r > adsr_pkg::LEVEL_FULL) ? adsr_pkg::LEVEL_FULL : sustain_r;
  assign sus_acc   = {sus_clamp, {FRAC_BITS{1'b0}}};
  assign head_room = FULL_ACC - level_r;
  assign above_sus = level_r - sus_acc;

  adsr_div #(
    .NUM_W (ACC_W),
    .DEN_W (adsr_pkg::TIME_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    stage_nxt     = stage_r;
    level_nxt     = level_r;
    slope_nxt     = slope_r;
    delta_nxt     = delta_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_level_nxt = out_level_r;
    out_phase_nxt = out_phase_r;
    div_start     = 1'b0;
    div_num       = FULL_ACC;
    div_den       = attack_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_chan.command)
            adsr_pkg::CMD_TICK: begin
              delta_nxt = DELTA_W'(slope_r) * DELTA_W'(n_sat);
              state_nxt = S_TICK;
            end
            adsr_pkg::CMD_NOTE_ON: begin
              level_nxt = '0;
              stage_nxt = adsr_pkg::PH_ATTACK;
              div_start = 1'b1;
              div_num   = FULL_ACC;
              div_den   = attack_r;
              state_nxt = S_DIV;
            end
            adsr_pkg::CMD_NOTE_OFF: begin
              if (stage_r != adsr_pkg::PH_IDLE) begin
                stage_nxt = adsr_pkg::PH_RELEASE;
                div_start = 1'b1;
                div_num   = level_r;
                div_den   = release_r;
                state_nxt = S_DIV;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_TICK: begin
        state_nxt = S_DONE;
        unique case (stage_r)
          adsr_pkg::PH_ATTACK: begin
            if (delta_r >= DELTA_W'(head_room)) begin
              level_nxt = FULL_ACC;
              stage_nxt = adsr_pkg::PH_DECAY;
              div_start = 1'b1;
              div_num   = FULL_ACC - sus_acc;
              div_den   = decay_r;
              state_nxt = S_DIV;
            end else begin
              level_nxt = level_r + delta_r[ACC_W-1:0];
            end
          end
          adsr_pkg::PH_DECAY: begin
            if ((level_r <= sus_acc) || (delta_r >= DELTA_W'(above_sus))) begin
              level_nxt = sus_acc;
              stage_nxt = adsr_pkg::PH_SUSTAIN;
              slope_nxt = '0;
            end else begin
              level_nxt = level_r - delta_r[ACC_W-1:0];
            end
          end
          adsr_pkg::PH_RELEASE: begin
            if (delta_r >= DELTA_W'(level_r)) begin
              level_nxt = '0;
              stage_nxt = adsr_pkg::PH_IDLE;
              slope_nxt = '0;
            end else begin
              level_nxt = level_r - delta_r[ACC_W-1:0];
            end
          end
          default: begin
          end
        endcase
      end
      S_DIV: begin
        if (div_stat.done) begin
          slope_nxt = div_quo;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = level_r[ACC_W-1 -: adsr_pkg::LEVEL_W];
          out_phase_nxt = stage_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stage_r     <= adsr_pkg::PH_IDLE;
      level_r     <= '0;
      slope_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stage_r     <= stage_nxt;
      level_r     <= level_nxt;
      slope_r     <= slope_nxt;
      out_valid_r <= out_valid_nxt;
    end
    delta_r     <= delta_nxt;
    out_level_r <= out_level_nxt;
    out_phase_r <= out_phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= adsr_pkg::RST_ATTACK;
      decay_r   <= adsr_pkg::RST_DECAY;
      sustain_r <= adsr_pkg::RST_SUSTAIN;
      release_r <= adsr_pkg::RST_RELEASE;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_chan.index)
        adsr_pkg::CFG_ATTACK:  attack_r  <= cfg_chan.data[adsr_pkg::TIME_W-1:0];
        adsr_pkg::CFG_DECAY:   decay_r   <= cfg_chan.data[adsr_pkg::TIME_W-1:0];
        adsr_pkg::CFG_SUSTAIN: sustain_r <= cfg_chan.data[adsr_pkg::LEVEL_W-1:0];
        adsr_pkg::CFG_RELEASE: release_r <= cfg_chan.data[adsr_pkg::TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.level     = out_level_r;
  assign out_chan.phase_now = out_phase_r;

`ifndef SYNTHESIS
  a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= FULL_ACC)
    else $error("Envelope level is above full scale.");

  a_idle_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_r == adsr_pkg::PH_IDLE) |-> (level_r == '0))
    else $error("Idle phase with a nonzero level.");

  a_sustain_flat: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_r == adsr_pkg::PH_SUSTAIN) |-> (slope_r == '0))
    else $error("Sustain phase with a nonzero slope.");

  a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("Divider started while busy.");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV))
    else $error("Divider finished outside of the slope wait.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_chan.ready)
    else $error("Command taken while the previous one is in progress.");
`endif

endmodule

`default_nettype wire
